FILE: src/utf8vp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8vp_pkg;

   // Default width of the byte counter
   localparam int COUNT_BITS_DEFAULT = 8;

   // Lead byte ranges
   localparam logic [7:0] ASCII_HI = 8'h7f;
   localparam logic [7:0] LEAD2_LO = 8'hc2;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD4_LO = 8'hf0;
   localparam logic [7:0] LEAD4_HI = 8'hf4;

   // Leads that restrict the second byte
   localparam logic [7:0] LEAD_E0 = 8'he0;
   localparam logic [7:0] LEAD_ED = 8'hed;
   localparam logic [7:0] LEAD_F0 = 8'hf0;
   localparam logic [7:0] LEAD_F4 = 8'hf4;

   // Second byte bounds
   localparam logic [7:0] E0_MIN = 8'ha0;
   localparam logic [7:0] ED_MAX = 8'h9f;
   localparam logic [7:0] F0_MIN = 8'h90;
   localparam logic [7:0] F4_MAX = 8'h8f;

   // Continuation byte tag (top two bits)
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Open sequence and stop flag
   typedef struct packed {
      logic [7:0] lead;
      logic [2:0] total;
      logic [2:0] seen;
      logic       stopped;
   } utf8vp_seq_type;

   // Sequence length announced by a lead byte; zero for an invalid lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b <= ASCII_HI) begin
         len = 3'd1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         len = 3'd2;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         len = 3'd3;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Overlong, surrogate or out-of-range form given by the second byte
   function automatic logic bad_second(input logic [7:0] lead, input logic [7:0] second);
      return (lead == LEAD_E0 && second < E0_MIN) ||
             (lead == LEAD_ED && second > ED_MAX) ||
             (lead == LEAD_F0 && second < F0_MIN) ||
             (lead == LEAD_F4 && second > F4_MAX);
   endfunction

endpackage

`default_nettype wire

FILE: src/utf8vp_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next scan state for one text byte
module utf8vp_step #(
   parameter int COUNT_BITS = utf8vp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic [7:0]                text_byte,
   input  wire logic [7:0]                budget,
   input  wire logic [COUNT_BITS-1:0]     count_cur,
   input  wire utf8vp_pkg::utf8vp_seq_type seq_cur,
   output logic [COUNT_BITS-1:0]          count_nxt,
   output utf8vp_pkg::utf8vp_seq_type     seq_nxt
);

   localparam int LW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   logic [LW-1:0] budget_ext;
   logic [LW-1:0] count_max_ext;
   logic [LW-1:0] limit;
   logic [2:0]    len;
   logic [LW:0]   sum;
   logic [2:0]    seen_inc;

   // Effective budget is capped by the counter range
   assign budget_ext    = LW'(budget);
   assign count_max_ext = LW'({COUNT_BITS{1'b1}});
   assign limit         = (budget_ext < count_max_ext) ? budget_ext : count_max_ext;

   assign len      = utf8vp_pkg::lead_length(text_byte);
   assign sum      = (LW+1)'(count_cur) + (LW+1)'(len);
   assign seen_inc = seq_cur.seen + 3'd1;

   always_comb begin
      count_nxt = count_cur;
      seq_nxt   = seq_cur;
      if (seq_cur.stopped) begin
         // absorb rest of text
      end else if (text_byte == 8'h00) begin
         seq_nxt.stopped = 1'b1;
      end else if (seq_cur.total == 3'd0) begin
         // lead byte
         if (len == 3'd0 || sum > {1'b0, limit}) begin
            seq_nxt.stopped = 1'b1;
         end else if (len == 3'd1) begin
            count_nxt = count_cur + COUNT_BITS'(1);
         end else begin
            seq_nxt.lead  = text_byte;
            seq_nxt.total = len;
            seq_nxt.seen  = 3'd1;
         end
      end else if (text_byte[7:6] != utf8vp_pkg::CONT_TAG) begin
         seq_nxt.stopped = 1'b1;
      end else if (seq_cur.seen == 3'd1 && utf8vp_pkg::bad_second(seq_cur.lead, text_byte)) begin
         seq_nxt.stopped = 1'b1;
      end else if (seen_inc >= seq_cur.total) begin
         // character complete
         count_nxt     = count_cur + COUNT_BITS'(seq_cur.total);
         seq_nxt.lead  = 8'h00;
         seq_nxt.total = 3'd0;
         seq_nxt.seen  = 3'd0;
      end else begin
         seq_nxt.seen = seen_inc;
      end
   end

endmodule

`default_nettype wire

FILE: src/utf8_valid_prefix_length_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Transfer                 | Content
// ---------+-----+--------------------------+-------------------------------------
// req_     | in  | req_tvalid & req_tready  | tdata[7:0] text_byte, tlast end_of_text
// rsp_     | out | rsp_tvalid & rsp_tready  | tdata[7:0] prefix_length
// csr_     | in  | csr_we                   | csr_wdata byte_budget
//
// One byte per cycle unless a last byte waits behind an untaken result.
// A byte is held in the input register, then the scan logic updates the state;
// a last byte loads the result register, which drives rsp_tvalid.
// Reset clears the scan state and sets the budget to 255.
// req_tready drops only while a last byte waits behind an untaken result.
module utf8_valid_prefix_length_core #(
   parameter int COUNT_BITS = utf8vp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // end_of_text
   // result stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] prefix_length
   // budget register
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   logic [7:0]                 budget_ff;
   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic                       in_last_ff;
   logic [COUNT_BITS-1:0]      count_ff;
   utf8vp_pkg::utf8vp_seq_type seq_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_data_ff;

   logic [COUNT_BITS-1:0]      count_in;
   utf8vp_pkg::utf8vp_seq_type seq_in;
   logic                       advance;

   // Held byte moves on unless it is a last byte blocked by a full result
   assign advance    = in_valid_ff && !(in_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   utf8vp_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .text_byte(in_byte_ff),
      .budget   (budget_ff),
      .count_cur(count_ff),
      .seq_cur  (seq_ff),
      .count_nxt(count_in),
      .seq_nxt  (seq_in)
   );

   // Budget register
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= 8'hff;
      end else if (csr_we) begin
         budget_ff <= csr_wdata;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Scan state; a last byte returns it to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seq_ff   <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            count_ff <= '0;
            seq_ff   <= '0;
         end else begin
            count_ff <= count_in;
            seq_ff   <= seq_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= 8'(count_in);
      end
   end

   // Scan state is clean after a last byte
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (count_ff == '0 && seq_ff.total == 3'd0 && !seq_ff.stopped))
      else $error("scan state not cleared after last byte");

   // An open sequence has seen fewer bytes than it needs
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff.total != 3'd0) |-> (seq_ff.seen != 3'd0 && seq_ff.seen < seq_ff.total
                                  && seq_ff.total >= 3'd2 && seq_ff.total <= 3'd4))
      else $error("open sequence bookkeeping broken");

   // No bytes counted as seen without an open sequence
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff.total == 3'd0) |-> (seq_ff.seen == 3'd0))
      else $error("seen count without open sequence");

   // A result appears only after a last byte left the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result without last byte");

   // Input stalls only behind a blocked last byte
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without cause");

endmodule

`default_nettype wire
